/* design/brb_pkg.sv */
// Shared types and constants for the byte ring buffer with peek.
// No dependencies; every other design file refers to it by scoped names.
package brb_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int OP_W = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W = 8;
    localparam int STAT_W = 2;
    // Width that holds a pointer plus an offset, and any offset itself
    localparam int SUM_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 24;

    // Register index of buffer_length
    localparam logic REG_BUFFER_LENGTH = 1'b0;
    localparam logic [CNT_W-1:0] LENGTH_RESET = CNT_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_NOP    = 2'd3
    } brb_op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } brb_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } brb_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_out;
    } brb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } brb_stat_t;

endpackage

/* design/byte_ring_buffer_with_peek_top.sv */
// Top level of the byte ring buffer with peek: stream ports, APB register.
// Depends on brb_pkg, brb_ctrl and brb_datapath.
//
// Each request (add, remove, peek or no-op) passes through the accept beat,
// an access on the byte memory (one write port and one read port whose
// read data is registered), and the load of the output register. That
// last step is held for as long as an earlier result still waits in the
// output register. The next request is taken while a finished result
// still waits in the output register. Requests are handled one at a time
// in arrival order; every request gives exactly one result beat.
// buffer_length sets the ring capacity in use (zero counts as one, values above
// 256 as 256) and should be written only while no request is in flight.
module byte_ring_buffer_with_peek_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [brb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [brb_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [brb_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] operation, [9:2] data_in, [17:10] position, rest zero
    input  logic [brb_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [9:2] data_out, [18:10] fill_count, [19] is_full,
    // [20] is_empty, rest zero
    output logic [brb_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int OP_LO    = 0;
    localparam int DIN_LO   = OP_LO + brb_pkg::OP_W;
    localparam int POS_LO   = DIN_LO + brb_pkg::BYTE_W;
    localparam int ST_LO    = 0;
    localparam int DOUT_LO  = ST_LO + brb_pkg::STAT_W;
    localparam int CNT_LO   = DOUT_LO + brb_pkg::BYTE_W;
    localparam int FULL_B   = CNT_LO + brb_pkg::CNT_W;
    localparam int EMPTY_B  = FULL_B + 1;
    localparam int OUT_USED = EMPTY_B + 1;

    logic [brb_pkg::CNT_W-1:0]  length_reg;
    logic [brb_pkg::CNT_W-1:0]  length_next;
    logic [brb_pkg::CNT_W-1:0]  cap;
    logic                       reg_hit;

    brb_pkg::brb_cmd_t          cmd;
    brb_pkg::brb_stat_t         stat;

    logic [brb_pkg::STAT_W-1:0] out_status;
    logic [brb_pkg::BYTE_W-1:0] out_data;
    logic [brb_pkg::CNT_W-1:0]  out_fill_count;
    logic                       out_is_full;
    logic                       out_is_empty;

    // Register decode: one word register at offset zero
    assign reg_hit = (paddr[2] == brb_pkg::REG_BUFFER_LENGTH);
    assign pready  = 1'b1;

    always_comb begin
        length_next = length_reg;
        if (psel && penable && pwrite && reg_hit) begin
            length_next = pwdata[brb_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= brb_pkg::LENGTH_RESET;
        end else begin
            length_reg <= length_next;
        end
    end

    assign prdata = reg_hit ? brb_pkg::CFG_DATA_W'(length_reg) : '0;

    // Saturate the length to the ring depth; zero counts as one
    always_comb begin
        if (length_reg == '0) begin
            cap = brb_pkg::CNT_W'(1);
        end else if (length_reg > brb_pkg::CNT_W'(brb_pkg::DEPTH)) begin
            cap = brb_pkg::CNT_W'(brb_pkg::DEPTH);
        end else begin
            cap = length_reg;
        end
    end

    brb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brb_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cap            (cap),
        .in_operation   (s_tdata[DIN_LO-1:OP_LO]),
        .in_data        (s_tdata[POS_LO-1:DIN_LO]),
        .in_position    (s_tdata[POS_LO+brb_pkg::POS_W-1:POS_LO]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_status     (out_status),
        .out_data       (out_data),
        .out_fill_count (out_fill_count),
        .out_is_full    (out_is_full),
        .out_is_empty   (out_is_empty)
    );

    // Pack the result beat, lowest field first
    assign m_tdata = {{(brb_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                      out_is_empty, out_is_full, out_fill_count, out_data, out_status};

endmodule

/* design/brb_ctrl.sv */
// Request sequencer for the byte ring buffer: accept, memory access, result load.
// Depends on brb_pkg for the state type and the command and status structs.
module brb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  brb_pkg::brb_stat_t  stat,
    output brb_pkg::brb_cmd_t   cmd
);

    brb_pkg::brb_state_t state_reg;
    brb_pkg::brb_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load_req = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            brb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = brb_pkg::ST_EXEC;
                end
            end
            brb_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = brb_pkg::ST_DONE;
            end
            brb_pkg::ST_DONE: begin
                // Hold the result until the output register frees up
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = brb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/brb_datapath.sv */
// Datapath of the byte ring buffer: request register, pointers, count,
// byte memory and output register. Depends on brb_pkg.
module brb_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  brb_pkg::brb_cmd_t              cmd,
    output brb_pkg::brb_stat_t             stat,
    input  logic [brb_pkg::CNT_W-1:0]      cap,
    input  logic [brb_pkg::OP_W-1:0]       in_operation,
    input  logic [brb_pkg::BYTE_W-1:0]     in_data,
    input  logic [brb_pkg::POS_W-1:0]      in_position,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [brb_pkg::STAT_W-1:0]     out_status,
    output logic [brb_pkg::BYTE_W-1:0]     out_data,
    output logic [brb_pkg::CNT_W-1:0]      out_fill_count,
    output logic                           out_is_full,
    output logic                           out_is_empty
);

    // Request held from accept until execution
    logic [brb_pkg::OP_W-1:0]   req_op_reg;
    logic [brb_pkg::BYTE_W-1:0] req_din_reg;
    logic [brb_pkg::POS_W-1:0]  req_pos_reg;

    logic [brb_pkg::PTR_W-1:0]  wr_idx_reg;
    logic [brb_pkg::PTR_W-1:0]  wr_idx_next;
    logic [brb_pkg::PTR_W-1:0]  rd_idx_reg;
    logic [brb_pkg::PTR_W-1:0]  rd_idx_next;
    logic [brb_pkg::CNT_W-1:0]  count_reg;
    logic [brb_pkg::CNT_W-1:0]  count_next;

    brb_pkg::brb_status_t       status_reg;
    brb_pkg::brb_status_t       status_next;
    logic                       use_rdata_reg;
    logic                       use_rdata_next;

    logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::DEPTH];
    logic [brb_pkg::BYTE_W-1:0] rdata_reg;
    logic [brb_pkg::PTR_W-1:0]  raddr;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [brb_pkg::STAT_W-1:0] out_status_reg;
    logic [brb_pkg::BYTE_W-1:0] out_data_reg;
    logic [brb_pkg::CNT_W-1:0]  out_count_reg;
    logic                       out_full_reg;
    logic                       out_empty_reg;

    logic [brb_pkg::PTR_W-1:0]  w_eff;
    logic [brb_pkg::PTR_W-1:0]  r_eff;
    logic [brb_pkg::CNT_W-1:0]  w_inc;
    logic [brb_pkg::CNT_W-1:0]  r_inc;
    logic [brb_pkg::PTR_W-1:0]  w_step;
    logic [brb_pkg::PTR_W-1:0]  r_step;
    logic [brb_pkg::SUM_W-1:0]  cap_wide;
    logic [brb_pkg::SUM_W-1:0]  pos_wide;
    logic [brb_pkg::SUM_W-1:0]  peek_sum;
    logic [brb_pkg::SUM_W-1:0]  peek_wrap;
    logic [brb_pkg::PTR_W-1:0]  peek_idx;
    logic                       add_ok;
    logic                       rem_ok;
    logic                       at_full;

    // Capture the request beat
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_op_reg  <= in_operation;
            req_din_reg <= in_data;
            req_pos_reg <= in_position;
        end
    end

    // Effective pointers: a pointer at or past a shrunk capacity reads as zero
    always_comb begin
        w_eff = ({1'b0, wr_idx_reg} < cap) ? wr_idx_reg : '0;
        r_eff = ({1'b0, rd_idx_reg} < cap) ? rd_idx_reg : '0;
        w_inc = {1'b0, w_eff} + brb_pkg::CNT_W'(1);
        r_inc = {1'b0, r_eff} + brb_pkg::CNT_W'(1);
        w_step = (w_inc >= cap) ? '0 : w_inc[brb_pkg::PTR_W-1:0];
        r_step = (r_inc >= cap) ? '0 : r_inc[brb_pkg::PTR_W-1:0];
    end

    // Peek address: write pointer plus offset, wrapped once by the capacity
    always_comb begin
        cap_wide  = brb_pkg::SUM_W'(cap);
        pos_wide  = brb_pkg::SUM_W'(req_pos_reg);
        peek_sum  = brb_pkg::SUM_W'(w_eff) + pos_wide;
        peek_wrap = (peek_sum >= cap_wide) ? peek_sum - cap_wide : peek_sum;
        peek_idx  = peek_wrap[brb_pkg::PTR_W-1:0];
    end

    // Decide the request outcome and next pointer and count values
    always_comb begin
        at_full        = (count_reg >= cap);
        add_ok         = 1'b0;
        rem_ok         = 1'b0;
        status_next    = brb_pkg::STAT_OK;
        use_rdata_next = 1'b0;
        raddr          = r_eff;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        count_next     = count_reg;
        unique case (brb_pkg::brb_op_t'(req_op_reg))
            brb_pkg::OP_ADD: begin
                if (at_full) begin
                    status_next = brb_pkg::STAT_FULL;
                end else begin
                    add_ok      = 1'b1;
                    wr_idx_next = w_step;
                    count_next  = count_reg + brb_pkg::CNT_W'(1);
                end
            end
            brb_pkg::OP_REMOVE: begin
                if (count_reg == '0) begin
                    status_next = brb_pkg::STAT_EMPTY;
                end else begin
                    rem_ok         = 1'b1;
                    use_rdata_next = 1'b1;
                    rd_idx_next    = r_step;
                    count_next     = count_reg - brb_pkg::CNT_W'(1);
                end
            end
            brb_pkg::OP_PEEK: begin
                raddr = peek_idx;
                if (pos_wide >= cap_wide) begin
                    status_next = brb_pkg::STAT_BADPOS;
                end else begin
                    use_rdata_next = 1'b1;
                end
            end
            default: begin
                status_next = brb_pkg::STAT_OK;
            end
        endcase
    end

    // Pointer and count registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else if (cmd.exec) begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    // Hold the outcome for the result load
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg    <= status_next;
            use_rdata_reg <= use_rdata_next;
        end
    end

    // Byte memory: one write and one registered read per access cycle
    always_ff @(posedge aclk) begin
        if (cmd.exec && add_ok) begin
            mem[w_eff] <= req_din_reg;
        end
        if (cmd.exec) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Output valid: set on load, drop when the beat is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_data_reg   <= use_rdata_reg ? rdata_reg : '0;
            out_count_reg  <= count_reg;
            out_full_reg   <= (count_reg >= cap);
            out_empty_reg  <= (count_reg == '0);
        end
    end

    assign stat.out_busy  = out_valid_reg && !m_tready;
    assign m_tvalid       = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_data       = out_data_reg;
    assign out_fill_count = out_count_reg;
    assign out_is_full    = out_full_reg;
    assign out_is_empty   = out_empty_reg;

    // The count never passes the ring depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= brb_pkg::CNT_W'(brb_pkg::DEPTH))
        else $error("fill count above ring depth");

    // A stored byte raises the count by one
    a_add_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && add_ok) |=> (count_reg == $past(count_reg) + brb_pkg::CNT_W'(1)))
        else $error("add did not advance the count");

    // A removed byte lowers the count by one
    a_rem_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && rem_ok) |=> (count_reg == $past(count_reg) - brb_pkg::CNT_W'(1)))
        else $error("remove did not lower the count");

    // Loading a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !stat.out_busy)
        else $error("result loaded over a pending beat");

endmodule

/* dv/byte_ring_buffer_with_peek_top_test.sv */
// Self-checking testbench for the byte ring buffer with peek: random add, remove, peek and
// no-op beats against a cycle-free ring predictor, with APB length changes between phases.
// Depends on brb_pkg and byte_ring_buffer_with_peek_top.
module byte_ring_buffer_with_peek_top_test;
    import brb_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 48;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_ADDR_W-1:0] LENGTH_ADDR = CFG_ADDR_W'(4 * REG_BUFFER_LENGTH);

    // Request beat, op in the lowest bits
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] data_in;
        brb_op_t           op;
    } req_t;

    // Result beat, status in the lowest bits
    typedef struct packed {
        logic              is_empty;
        logic              is_full;
        logic [CNT_W-1:0]  fill_count;
        logic [BYTE_W-1:0] data_out;
        brb_status_t       status;
    } reply_t;

    // Ring contents, pointers, count and the length register
    typedef struct packed {
        logic [DEPTH-1:0][BYTE_W-1:0] mem;
        logic [DEPTH-1:0]             filled;
        logic [PTR_W-1:0]             wr_idx;
        logic [PTR_W-1:0]             rd_idx;
        logic [CNT_W-1:0]             count;
        logic [CNT_W-1:0]             length_reg;
    } ring_t;

    typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    req_t     pending_reqs[$];
    reply_t   expected_replies[$];
    ring_t    chk_ring;
    ring_t    gen_ring;
    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left = 1;
    int       gap_left = 0;
    bit       rx_hold_req = 1'b0;
    bit       hold_armed = 1'b0;
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_STEADY;
    int       rx_mode_left = 0;

    byte_ring_buffer_with_peek_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Saturate the length register to the usable capacity
    function automatic int unsigned ring_cap(logic [CNT_W-1:0] len);
        if (len == 0) return 1;
        if (len > DEPTH) return DEPTH;
        return len;
    endfunction

    // Apply one request to a ring and form its result
    function automatic void ring_apply(inout ring_t rg, input req_t rq, output reply_t rsp);
        int unsigned cap;
        int unsigned w;
        int unsigned r;
        int unsigned slot;
        cap = ring_cap(rg.length_reg);
        w = (rg.wr_idx < cap) ? rg.wr_idx : 0;
        r = (rg.rd_idx < cap) ? rg.rd_idx : 0;
        rsp = '0;
        rsp.status = STAT_OK;
        case (rq.op)
            OP_ADD: begin
                if (rg.count >= cap) begin
                    rsp.status = STAT_FULL;
                end else begin
                    rg.mem[w] = rq.data_in;
                    rg.filled[w] = 1'b1;
                    rg.wr_idx = PTR_W'((w + 1 >= cap) ? 0 : w + 1);
                    rg.count = rg.count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (rg.count == 0) begin
                    rsp.status = STAT_EMPTY;
                end else begin
                    rsp.data_out = rg.mem[r];
                    rg.rd_idx = PTR_W'((r + 1 >= cap) ? 0 : r + 1);
                    rg.count = rg.count - 1'b1;
                end
            end
            OP_PEEK: begin
                if (rq.position >= cap) begin
                    rsp.status = STAT_BADPOS;
                end else begin
                    slot = w + rq.position;
                    if (slot >= cap) slot -= cap;
                    rsp.data_out = rg.mem[slot];
                end
            end
            default: ;
        endcase
        rsp.fill_count = rg.count;
        rsp.is_full = (rg.count >= cap);
        rsp.is_empty = (rg.count == 0);
    endfunction

    // True when the request would read an entry never written
    function automatic bit ring_reads_blank(ring_t rg, req_t rq);
        int unsigned cap;
        int unsigned slot;
        cap = ring_cap(rg.length_reg);
        if (rq.op == OP_REMOVE && rg.count != 0)
            return !rg.filled[(rg.rd_idx < cap) ? rg.rd_idx : 0];
        if (rq.op == OP_PEEK && rq.position < cap) begin
            slot = ((rg.wr_idx < cap) ? rg.wr_idx : 0) + rq.position;
            if (slot >= cap) slot -= cap;
            return !rg.filled[slot];
        end
        return 1'b0;
    endfunction

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Queue a request; turn reads of blank entries into no-ops
    task automatic queue_req(brb_op_t op, logic [BYTE_W-1:0] din, logic [POS_W-1:0] pos);
        req_t   rq;
        reply_t unused;
        rq.op = op;
        rq.data_in = din;
        rq.position = pos;
        if (ring_reads_blank(gen_ring, rq)) rq.op = OP_NOP;
        ring_apply(gen_ring, rq, unused);
        pending_reqs.push_back(rq);
    endtask

    // Mostly add/remove runs that swing between full and empty, with peeks and noise
    task automatic queue_random(int count);
        int unsigned cap;
        int unsigned roll;
        int unsigned add_pct;
        logic [POS_W-1:0] pos;
        add_pct = 70;
        for (int i = 0; i < count; i++) begin
            cap = ring_cap(gen_ring.length_reg);
            if (i % 12 == 11) add_pct = (add_pct > 50) ? 25 : 75;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                queue_req(OP_NOP, BYTE_W'($urandom), POS_W'($urandom));
            end else if (roll < 30) begin
                if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 255));
                else pos = POS_W'($urandom_range(0, cap - 1));
                queue_req(OP_PEEK, BYTE_W'($urandom), pos);
            end else if ($urandom_range(0, 99) < add_pct) begin
                queue_req(OP_ADD, BYTE_W'($urandom), POS_W'($urandom));
            end else begin
                queue_req(OP_REMOVE, BYTE_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    // Hold until every queued beat is sent and every result is back
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_replies.size() != 0) @(posedge aclk);
    endtask

    // Write buffer_length over APB, then read it back
    task automatic write_length(logic [CNT_W-1:0] value);
        logic [CFG_DATA_W-1:0] readback;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LENGTH_ADDR;
        pwdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        chk_ring.length_reg = value;
        gen_ring.length_reg = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== CFG_DATA_W'(value))
            report_error($sformatf("buffer_length readback: expected %0d, got %0d",
                value, readback));
    endtask

    // Send request beats in bursts; predict each accepted beat
    always @(posedge aclk) begin : request_driver
        req_t   beat;
        reply_t outcome;
        logic   offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            chk_ring = '0;
            chk_ring.length_reg = LENGTH_RESET;
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                beat = req_t'(s_tdata[$bits(req_t)-1:0]);
                ring_apply(chk_ring, beat, outcome);
                expected_replies.push_back(outcome);
                void'(pending_reqs.pop_front());
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                offer = 1'b0;
            end else begin
                offer = (pending_reqs.size() != 0);
            end
            s_tvalid <= offer;
            if (offer) s_tdata <= IN_TDATA_W'(pending_reqs[0]);
        end
    end

    // Check each result beat; stall the result side on its own pattern
    always @(posedge aclk) begin : result_monitor
        reply_t got;
        reply_t want;
        logic   ready_next;
        if (aresetn && m_tvalid && m_tready) begin
            got = reply_t'(m_tdata[$bits(reply_t)-1:0]);
            if (expected_replies.size() == 0) begin
                report_error($sformatf("unexpected result beat %h", m_tdata));
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status || got.data_out !== want.data_out ||
                        got.fill_count !== want.fill_count || got.is_full !== want.is_full ||
                        got.is_empty !== want.is_empty)
                    report_error($sformatf({"result mismatch: expected status %0d data %h ",
                        "count %0d full %b empty %b, got status %0d data %h count %0d ",
                        "full %b empty %b"}, want.status, want.data_out, want.fill_count,
                        want.is_full, want.is_empty, got.status, got.data_out,
                        got.fill_count, got.is_full, got.is_empty));
            end
        end
        // arm one long hold-off per request
        if (rx_hold_req && !hold_armed) begin
            hold_armed = 1'b1;
            hold_left = LONG_HOLD;
        end else if (!rx_hold_req) begin
            hold_armed = 1'b0;
        end
        if (rx_mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 96);
        end else begin
            rx_mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: ready_next = 1'b1;
                RX_LIGHT:  ready_next = ($urandom_range(0, 3) != 0);
                default:   ready_next = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_tready <= ready_next;
    end

    // Bound the run
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("byte_ring_buffer_with_peek_top_test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned phase_len [8];
        phase_len = '{0, 17, 2, 1, 0, 511, 256, 9};
        phase_len[0] = $urandom_range(5, 255);
        gen_ring = '0;
        gen_ring.length_reg = LENGTH_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full-size ring: empty remove, no-op with all ones, wrapped peeks, drain
        queue_req(OP_REMOVE, 8'h00, 8'h00);
        queue_req(OP_NOP, 8'hFF, 8'hFF);
        queue_req(OP_ADD, 8'h00, 8'h00);
        queue_req(OP_ADD, 8'hFF, 8'h00);
        queue_req(OP_ADD, 8'h5A, 8'h00);
        queue_req(OP_PEEK, 8'h00, 8'd253);
        queue_req(OP_PEEK, 8'h00, 8'd255);
        queue_req(OP_PEEK, 8'h00, 8'd254);
        queue_req(OP_REMOVE, 8'h00, 8'h00);
        queue_req(OP_REMOVE, 8'h00, 8'h00);
        queue_req(OP_REMOVE, 8'h00, 8'h00);
        queue_req(OP_REMOVE, 8'h00, 8'h00);
        wait_idle();

        // Four-entry ring with stale pointers: bad positions, fill, refused add, wrap
        write_length(9'd4);
        queue_req(OP_PEEK, 8'h00, 8'd4);
        queue_req(OP_PEEK, 8'h00, 8'd128);
        queue_req(OP_ADD, 8'h11, 8'h00);
        queue_req(OP_ADD, 8'h22, 8'h00);
        queue_req(OP_ADD, 8'h33, 8'h00);
        queue_req(OP_ADD, 8'h44, 8'h00);
        queue_req(OP_ADD, 8'h55, 8'h00);
        queue_req(OP_PEEK, 8'h00, 8'd3);
        queue_req(OP_PEEK, 8'h00, 8'd0);
        queue_req(OP_REMOVE, 8'h00, 8'h00);
        queue_req(OP_REMOVE, 8'h00, 8'h00);
        queue_req(OP_ADD, 8'h66, 8'h00);
        wait_idle();

        // Random phases; lengths shrink and grow over the leftover contents
        for (int p = 0; p < 8; p++) begin
            write_length(CNT_W'(phase_len[p]));
            if (phase_len[p] == 511) rx_hold_req = 1'b1;
            queue_random(PHASE_ITEMS);
            wait_idle();
            rx_hold_req = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("byte_ring_buffer_with_peek_top_test passed");
        else
            $display("byte_ring_buffer_with_peek_top_test failed");
        $finish;
    end
endmodule
